@@ rtl/iopd_pkg.sv @@
`default_nettype none

package iopd_pkg;

	localparam int REGION_COUNT = 8;
	localparam int REG_SLOTS    = 8;
	localparam int IDX_W        = $clog2(REG_SLOTS);
	localparam int PADDR_W      = IDX_W + 3;
	localparam int APB_DATA_W   = 64;
	localparam int REGION_W     = 34;
	localparam int PORT_W       = 16;
	localparam int BYTE_W       = 8;

	localparam logic [BYTE_W-1:0] MISS_READ_DATA = 8'hFF;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	// Packed to match the register layout: bit 33 enable, 32 alias, 31:16 end, 15:0 start.
	typedef struct packed {
		logic              enable;
		logic              lb_alias;
		logic [PORT_W-1:0] end_port;
		logic [PORT_W-1:0] start_port;
	} region_t;

	typedef region_t [REG_SLOTS-1:0] region_vec_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [PORT_W-1:0]    port;
		logic [BYTE_W-1:0]    wbyte;
		logic [REG_SLOTS-1:0] full_match;
		logic [REG_SLOTS-1:0] low_match;
	} match_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [PORT_W-1:0] port;
		logic [BYTE_W-1:0] wbyte;
		logic              hit;
		logic [IDX_W-1:0]  idx;
		logic              use_low;
		logic [PORT_W-1:0] start_port;
	} select_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  idx;
		logic [PORT_W-1:0] offset;
		cmd_t              cmd;
		logic [BYTE_W-1:0] data;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/iopd_regs.sv @@
`default_nettype none

module iopd_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [iopd_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [iopd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [iopd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output iopd_pkg::region_vec_t                  regions
);

	iopd_pkg::region_t          region_q [iopd_pkg::REG_SLOTS];
	logic [iopd_pkg::IDX_W-1:0] sel_idx;
	logic                       wr_en;

	assign sel_idx = paddr[iopd_pkg::PADDR_W-1:3];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iopd_pkg::REG_SLOTS; i++) begin
				region_q[i] <= '0;
			end
		end else if (wr_en) begin
			// drop bits above the descriptor
			region_q[sel_idx] <= iopd_pkg::region_t'(pwdata[iopd_pkg::REGION_W-1:0]);
		end
	end

	always_comb begin
		prdata = {{(iopd_pkg::APB_DATA_W-iopd_pkg::REGION_W){1'b0}}, region_q[sel_idx]};
		for (int i = 0; i < iopd_pkg::REG_SLOTS; i++) begin
			regions[i] = region_q[i];
		end
	end

endmodule

`default_nettype wire

@@ rtl/iopd_match.sv @@
`default_nettype none

module iopd_match (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire iopd_pkg::cmd_t                     cmd,
	input  wire logic [iopd_pkg::PORT_W-1:0]        port,
	input  wire logic [iopd_pkg::BYTE_W-1:0]        wbyte,
	input  wire iopd_pkg::region_vec_t              regions,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output iopd_pkg::match_t                        out_s1
);

	logic                           valid_s1;
	iopd_pkg::match_t               data_s1;
	logic [iopd_pkg::REG_SLOTS-1:0] full_m;
	logic [iopd_pkg::REG_SLOTS-1:0] low_m;
	logic [iopd_pkg::PORT_W-1:0]    low_port;

	assign low_port = {{(iopd_pkg::PORT_W-8){1'b0}}, port[7:0]};

	// Compare every active region in parallel; an end of zero covers the top of the space
	// in the full compare and never matches in the low-byte compare.
	always_comb begin
		full_m = '0;
		low_m  = '0;
		for (int i = 0; i < iopd_pkg::REGION_COUNT; i++) begin
			full_m[i] = regions[i].enable && (port >= regions[i].start_port)
				&& ((regions[i].end_port == '0) || (port < regions[i].end_port));
			low_m[i]  = regions[i].enable && regions[i].lb_alias
				&& (low_port >= regions[i].start_port) && (low_port < regions[i].end_port);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.cmd        <= cmd;
			data_s1.port       <= port;
			data_s1.wbyte      <= wbyte;
			data_s1.full_match <= full_m;
			data_s1.low_match  <= low_m;
		end
	end

	assign out_valid = valid_s1;
	assign out_s1    = data_s1;

endmodule

`default_nettype wire

@@ rtl/iopd_select.sv @@
`default_nettype none

module iopd_select (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire iopd_pkg::match_t      in_s1,
	input  wire iopd_pkg::region_vec_t regions,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output iopd_pkg::select_t          out_s2
);

	logic                           valid_s2;
	iopd_pkg::select_t              data_s2;
	logic [iopd_pkg::REG_SLOTS-1:0] pick;
	logic                           use_low;
	logic                           hit;
	logic [iopd_pkg::IDX_W-1:0]     idx;

	// Any full-port match beats every low-byte match.
	assign use_low = (in_s1.full_match == '0);
	assign pick    = use_low ? in_s1.low_match : in_s1.full_match;
	assign hit     = (pick != '0);

	// Scan down so the lowest set index wins.
	always_comb begin
		idx = '0;
		for (int i = iopd_pkg::REG_SLOTS - 1; i >= 0; i--) begin
			if (pick[i]) begin
				idx = iopd_pkg::IDX_W'(i);
			end
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.cmd        <= in_s1.cmd;
			data_s2.port       <= in_s1.port;
			data_s2.wbyte      <= in_s1.wbyte;
			data_s2.hit        <= hit;
			data_s2.idx        <= idx;
			data_s2.use_low    <= use_low;
			data_s2.start_port <= regions[idx].start_port;
		end
	end

	assign out_valid = valid_s2;
	assign out_s2    = data_s2;

endmodule

`default_nettype wire

@@ rtl/iopd_result.sv @@
`default_nettype none

module iopd_result (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire iopd_pkg::select_t in_s2,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output iopd_pkg::result_t      out_s3
);

	logic                        valid_s3;
	iopd_pkg::result_t           data_s3;
	logic [iopd_pkg::PORT_W-1:0] base;
	logic [iopd_pkg::PORT_W-1:0] offset;
	logic [iopd_pkg::BYTE_W-1:0] data;

	assign base   = in_s2.use_low ? {{(iopd_pkg::PORT_W-8){1'b0}}, in_s2.port[7:0]} : in_s2.port;
	assign offset = in_s2.hit ? (base - in_s2.start_port) : '0;

	always_comb begin
		if (in_s2.cmd == iopd_pkg::CMD_WRITE) begin
			data = in_s2.wbyte;
		end else if (in_s2.hit) begin
			data = '0;
		end else begin
			data = iopd_pkg::MISS_READ_DATA;
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3.hit    <= in_s2.hit;
			data_s3.idx    <= in_s2.idx;
			data_s3.offset <= offset;
			data_s3.cmd    <= in_s2.cmd;
			data_s3.data   <= data;
		end
	end

	assign out_valid = valid_s3;
	assign out_s3    = data_s3;

endmodule

`default_nettype wire

@@ rtl/io_port_region_decoder_core.sv @@
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: port_address, write_byte; tuser: cmd
// m_        out  m_tvalid/m_tready  tdata: hit, region_index, device_offset, data_byte;
//                                   tuser: is_write
// apb       in   psel/penable       region_0_word .. region_7_word at 8*i, 34 bits each
//
// One beat enters per cycle while m_tready does not hold the stages; each result is registered
// in turn by the compare, priority select and offset/data stages before it leaves
// (compare stage, priority select stage, offset/data stage).
// Reset clears all region descriptors (every region disabled) and empties the pipeline.
// A stall on m_tready holds the stages; bubbles are filled, so s_tready drops only
// when all three stages are full and the result is not taken.
// Write region descriptors only while no beat is in flight.
`default_nettype none

module io_port_region_decoder_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [23:0]                     s_tdata, // port_address[15:0], write_byte[23:16]
	input  wire logic [0:0]                      s_tuser, // cmd[0]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [31:0]                          m_tdata, // hit[0], region_index[3:1],
	                                                      // device_offset[19:4],
	                                                      // data_byte[27:20], zero[31:28]
	output logic [0:0]                           m_tuser, // is_write[0]
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [iopd_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [iopd_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [iopd_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	iopd_pkg::region_vec_t regions;
	iopd_pkg::match_t      mt_s1;
	iopd_pkg::select_t     sel_s2;
	iopd_pkg::result_t     res_s3;
	logic                  v1;
	logic                  v2;
	logic                  r2;
	logic                  r3;

	iopd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regions (regions)
	);

	iopd_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (iopd_pkg::cmd_t'(s_tuser[0])),
		.port      (s_tdata[15:0]),
		.wbyte     (s_tdata[23:16]),
		.regions   (regions),
		.out_valid (v1),
		.out_ready (r2),
		.out_s1    (mt_s1)
	);

	iopd_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2),
		.in_s1     (mt_s1),
		.regions   (regions),
		.out_valid (v2),
		.out_ready (r3),
		.out_s2    (sel_s2)
	);

	iopd_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r3),
		.in_s2     (sel_s2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_s3    (res_s3)
	);

	assign m_tdata = {4'b0000, res_s3.data, res_s3.offset, res_s3.idx, res_s3.hit};
	assign m_tuser = res_s3.cmd;

`ifndef SYNTHESIS
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_s3.hit |-> (res_s3.idx == '0) && (res_s3.offset == '0))
		else $error("miss result carries a region index or offset");

	a_read_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s3.hit && (res_s3.cmd == iopd_pkg::CMD_READ) |-> (res_s3.data == '0))
		else $error("read hit returns nonzero data");

	a_read_miss_ff: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_s3.hit && (res_s3.cmd == iopd_pkg::CMD_READ)
		|-> (res_s3.data == iopd_pkg::MISS_READ_DATA))
		else $error("read miss does not return the miss pattern");

	a_full_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && v1 && v2)
		else $error("input held off while the pipeline has room");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s3.hit |-> (int'(res_s3.idx) < iopd_pkg::REGION_COUNT))
		else $error("hit names a region beyond the active count");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_io_port_region_decoder_core.sv @@
`timescale 1ns / 1ps

module tb_io_port_region_decoder_core;
	import iopd_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 9;
	localparam int LIMIT_NS     = 5_000_000;
	localparam int PHASE_COUNT  = 8;
	localparam int PHASE_BEATS  = 130;
	localparam int TAIL_CYCLES  = 8;
	localparam int MAX_IDLE     = 13;
	localparam int RESET_ROWS   = 5;
	localparam int ROW_COUNT    = 24;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] port;
		logic [7:0]  wbyte;
		logic        typed;
		result_t     want;
	} access_row_t;

	// Rows before RESET_ROWS run with every region disabled; the rest run against the
	// directed region set below.
	localparam access_row_t ACCESS_ROWS [0:ROW_COUNT-1] = '{
		'{CMD_READ,  16'h0000, 8'h00, 1'b1, '{1'b0, 3'd0, 16'h0000, CMD_READ,  8'hFF}},
		'{CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1, '{1'b0, 3'd0, 16'h0000, CMD_WRITE, 8'hFF}},
		'{CMD_WRITE, 16'h8000, 8'h00, 1'b1, '{1'b0, 3'd0, 16'h0000, CMD_WRITE, 8'h00}},
		'{CMD_READ,  16'hFFFF, 8'hFF, 1'b1, '{1'b0, 3'd0, 16'h0000, CMD_READ,  8'hFF}},
		'{CMD_WRITE, 16'h00FF, 8'h5A, 1'b1, '{1'b0, 3'd0, 16'h0000, CMD_WRITE, 8'h5A}},
		'{CMD_READ,  16'h0060, 8'h00, 1'b0, '0},
		'{CMD_WRITE, 16'h0063, 8'hA5, 1'b0, '0},
		'{CMD_READ,  16'h0064, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'h0040, 8'hFF, 1'b0, '0},
		'{CMD_WRITE, 16'h006F, 8'h5A, 1'b0, '0},
		'{CMD_READ,  16'h0070, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'h1041, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'h1062, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'h0100, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'hFF00, 8'h00, 1'b0, '0},
		'{CMD_WRITE, 16'hFFFF, 8'h11, 1'b0, '0},
		'{CMD_READ,  16'h0505, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'h0600, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'h8025, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'h0025, 8'h00, 1'b0, '0},
		'{CMD_WRITE, 16'h1234, 8'h77, 1'b0, '0},
		'{CMD_READ,  16'h2050, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'h7777, 8'h00, 1'b0, '0},
		'{CMD_READ,  16'hFEFF, 8'h00, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata  = '0; // port_address[15:0], write_byte[23:16]
	logic [0:0]            s_tuser  = '0; // cmd[0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;       // hit[0], region_index[3:1], device_offset[19:4],
	                                      // data_byte[27:20], zero[31:28]
	logic [0:0]            m_tuser;       // is_write[0]
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [PADDR_W-1:0]    paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Travels with each beat so the monitor knows whether a fixed result was given.
	logic                  beat_typed = 1'b0;
	result_t               beat_want  = '0;

	region_t               model_regions [REG_SLOTS];
	result_t               expected_decodes [$];
	logic [63:0]           region_words [REG_SLOTS];
	int                    mismatch_count = 0;
	bit                    quiet_tail = 1'b0;
	int                    stall_left = 0;

	io_port_region_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic result_t predict_decode(cmd_t cmd, logic [15:0] port, logic [7:0] wbyte);
		result_t     res;
		logic [16:0] span_end;
		logic [15:0] low;
		bit          found;
		res   = '0;
		res.cmd = cmd;
		found = 1'b0;
		low   = {8'h00, port[7:0]};
		for (int i = 0; i < REGION_COUNT; i++) begin
			span_end = (model_regions[i].end_port == '0) ? 17'h10000
				: {1'b0, model_regions[i].end_port};
			if (!found && model_regions[i].enable && port >= model_regions[i].start_port
					&& {1'b0, port} < span_end) begin
				found      = 1'b1;
				res.idx    = i[IDX_W-1:0];
				res.offset = port - model_regions[i].start_port;
			end
		end
		// Alias pass: an end of zero stays zero here, so it never matches.
		for (int i = 0; i < REGION_COUNT; i++) begin
			if (!found && model_regions[i].enable && model_regions[i].lb_alias
					&& low >= model_regions[i].start_port
					&& low < model_regions[i].end_port) begin
				found      = 1'b1;
				res.idx    = i[IDX_W-1:0];
				res.offset = low - model_regions[i].start_port;
			end
		end
		res.hit  = found;
		res.data = (cmd == CMD_WRITE) ? wbyte : (found ? 8'h00 : MISS_READ_DATA);
		return res;
	endfunction

	function automatic logic [63:0] pack_region(logic en, logic lb, logic [15:0] e,
			logic [15:0] s);
		// Set every bit above the descriptor so that dropping them is exercised.
		return {30'h3FFF_FFFF, en, lb, e, s};
	endfunction

	function automatic logic [63:0] directed_region(int idx);
		case (idx)
			0: return pack_region(1'b1, 1'b0, 16'h0064, 16'h0060);
			1: return pack_region(1'b1, 1'b1, 16'h0070, 16'h0040);
			2: return pack_region(1'b0, 1'b1, 16'h0000, 16'h0000);
			3: return pack_region(1'b1, 1'b1, 16'h0100, 16'h0100);
			4: return pack_region(1'b1, 1'b0, 16'h0000, 16'hFF00);
			5: return pack_region(1'b1, 1'b1, 16'h0030, 16'h0020);
			6: return pack_region(1'b1, 1'b1, 16'h0010, 16'h0000);
			default: return pack_region(1'b1, 1'b0, 16'h0600, 16'h0500);
		endcase
	endfunction

	function automatic logic [63:0] random_region();
		logic [15:0] s;
		logic [15:0] len;
		int          kind;
		kind = $urandom_range(0, 9);
		if (kind == 0)
			return {$urandom, $urandom};
		if (kind == 1)
			return {30'($urandom), 1'b1, 1'($urandom), 16'h0000, 16'($urandom)};
		s   = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
		len = 16'($urandom_range(1, 64));
		return {30'($urandom), 1'($urandom_range(0, 6) != 0), 1'($urandom), 16'(s + len), s};
	endfunction

	// Aim most ports into a region or its low-byte alias; the rest land anywhere.
	function automatic logic [15:0] pick_port();
		int          mode;
		int          k;
		logic [15:0] s;
		logic [15:0] e;
		logic [16:0] span;
		mode = $urandom_range(0, 9);
		k    = $urandom_range(0, REG_SLOTS - 1);
		s    = model_regions[k].start_port;
		e    = model_regions[k].end_port;
		if (e == '0)
			span = 17'h10000 - {1'b0, s};
		else if (e > s)
			span = {1'b0, e} - {1'b0, s};
		else
			span = '0;
		if (mode < 4 && span != '0)
			return 16'({1'b0, s} + ($urandom % span));
		if (mode < 7)
			return {8'($urandom), 8'(s[7:0] + $urandom_range(0, 15))};
		return 16'($urandom);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic send_access(cmd_t cmd, logic [15:0] port, logic [7:0] wbyte, logic typed,
			result_t want);
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, MAX_IDLE);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tdata    <= {wbyte, port};
		s_tuser    <= cmd;
		beat_typed <= typed;
		beat_want  <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain_decodes();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_decodes.size() != 0) @(posedge clk);
	endtask

	// Write all descriptors back to back; psel stays high between writes.
	task automatic program_regions();
		for (int i = 0; i < REG_SLOTS; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= PADDR_W'(i * 8);
			pwdata  <= region_words[i];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			model_regions[i] = region_t'(region_words[i][REGION_W-1:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, MAX_IDLE) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : beat_monitor
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_decodes.insert(expected_decodes.size(), beat_typed ? beat_want
					: predict_decode(cmd_t'(s_tuser[0]), s_tdata[15:0], s_tdata[23:16]));
			if (m_tvalid && m_tready) begin
				if (expected_decodes.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata, 32'h0);
				end else begin
					want = expected_decodes.pop_front();
					if (m_tdata[0] !== want.hit)
						report_mismatch("hit", m_tdata[0], want.hit);
					if (m_tdata[3:1] !== want.idx)
						report_mismatch("region_index", m_tdata[3:1], want.idx);
					if (m_tdata[19:4] !== want.offset)
						report_mismatch("device_offset", m_tdata[19:4], want.offset);
					if (m_tuser[0] !== want.cmd)
						report_mismatch("is_write", m_tuser[0], want.cmd);
					if (m_tdata[27:20] !== want.data)
						report_mismatch("data_byte", m_tdata[27:20], want.data);
					if (m_tdata[31:28] !== 4'h0)
						report_mismatch("tdata pad", m_tdata[31:28], 32'h0);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < REG_SLOTS; i++)
			model_regions[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < ROW_COUNT; r++) begin
			if (r == RESET_ROWS) begin
				drain_decodes();
				for (int i = 0; i < REG_SLOTS; i++)
					region_words[i] = directed_region(i);
				program_regions();
			end
			send_access(ACCESS_ROWS[r].cmd, ACCESS_ROWS[r].port, ACCESS_ROWS[r].wbyte,
				ACCESS_ROWS[r].typed, ACCESS_ROWS[r].want);
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_decodes();
			for (int i = 0; i < REG_SLOTS; i++) begin
				case (ph)
					// every region enabled but empty: start equals end at the top port
					0: region_words[i] = '1;
					// every region spans the whole port space
					1: region_words[i] = pack_region(1'b1, 1'b1, 16'h0000, 16'h0000);
					default: region_words[i] = random_region();
				endcase
			end
			program_regions();
			quiet_tail = (ph == PHASE_COUNT - 1);
			for (int n = 0; n < PHASE_BEATS; n++)
				send_access(cmd_t'($urandom_range(0, 1)), pick_port(), 8'($urandom), 1'b0, '0);
		end

		drain_decodes();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
